@@ rtl/lpe_pkg.sv @@
// ----------------------------------------------------------------------------
// Legendre evaluator package
// Shared widths, microcode encoding, control ROM and divider control type.
// ----------------------------------------------------------------------------
package lpe_pkg;

   localparam int DEGREE_W   = 5;
   localparam int VALUE_W    = 32;
   localparam int ACC_W      = 64;
   localparam int DIV_BITS   = 8;
   localparam int DIV_STEPS  = ACC_W / DIV_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

   localparam int UADDR_W = 4;
   localparam int OP_W    = 3;
   localparam int COND_W  = 3;

   // microcode addresses
   localparam logic [UADDR_W-1:0] UA_OUT   = 4'd0;
   localparam logic [UADDR_W-1:0] UA_IDLE  = 4'd1;
   localparam logic [UADDR_W-1:0] UA_CHECK = 4'd2;
   localparam logic [UADDR_W-1:0] UA_MUL   = 4'd3;
   localparam logic [UADDR_W-1:0] UA_SCALE = 4'd4;
   localparam logic [UADDR_W-1:0] UA_TERM  = 4'd5;
   localparam logic [UADDR_W-1:0] UA_NUM   = 4'd6;
   localparam logic [UADDR_W-1:0] UA_DIV   = 4'd7;
   localparam logic [UADDR_W-1:0] UA_UPD   = 4'd8;

   // datapath operations
   localparam logic [OP_W-1:0] OP_NONE   = 3'd0;
   localparam logic [OP_W-1:0] OP_LOAD   = 3'd1;
   localparam logic [OP_W-1:0] OP_MUL    = 3'd2;
   localparam logic [OP_W-1:0] OP_SCALE  = 3'd3;
   localparam logic [OP_W-1:0] OP_TERM   = 3'd4;
   localparam logic [OP_W-1:0] OP_NUM    = 3'd5;
   localparam logic [OP_W-1:0] OP_DIV    = 3'd6;
   localparam logic [OP_W-1:0] OP_UPDATE = 3'd7;

   // jump conditions
   localparam logic [COND_W-1:0] COND_NEVER    = 3'd0;
   localparam logic [COND_W-1:0] COND_ALWAYS   = 3'd1;
   localparam logic [COND_W-1:0] COND_NO_REQ   = 3'd2;
   localparam logic [COND_W-1:0] COND_DONE     = 3'd3;
   localparam logic [COND_W-1:0] COND_DIV_BUSY = 3'd4;
   localparam logic [COND_W-1:0] COND_OUT_BUSY = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]    op;
      logic               emit;
      logic [COND_W-1:0]  cond;
      logic [UADDR_W-1:0] target;
   } ucode_word_type;

   typedef struct packed {
      logic load;
      logic step;
   } lpe_div_ctl_type;

   function automatic ucode_word_type ucode_rom(input logic [UADDR_W-1:0] addr);
      ucode_word_type w;
      w = '{op: OP_NONE, emit: 1'b0, cond: COND_ALWAYS, target: UA_IDLE};
      case (addr)
         UA_OUT:   w = '{op: OP_NONE,   emit: 1'b1, cond: COND_OUT_BUSY, target: UA_OUT};
         UA_IDLE:  w = '{op: OP_LOAD,   emit: 1'b0, cond: COND_NO_REQ,   target: UA_IDLE};
         UA_CHECK: w = '{op: OP_NONE,   emit: 1'b0, cond: COND_DONE,     target: UA_OUT};
         UA_MUL:   w = '{op: OP_MUL,    emit: 1'b0, cond: COND_NEVER,    target: UA_IDLE};
         UA_SCALE: w = '{op: OP_SCALE,  emit: 1'b0, cond: COND_NEVER,    target: UA_IDLE};
         UA_TERM:  w = '{op: OP_TERM,   emit: 1'b0, cond: COND_NEVER,    target: UA_IDLE};
         UA_NUM:   w = '{op: OP_NUM,    emit: 1'b0, cond: COND_NEVER,    target: UA_IDLE};
         UA_DIV:   w = '{op: OP_DIV,    emit: 1'b0, cond: COND_DIV_BUSY, target: UA_DIV};
         UA_UPD:   w = '{op: OP_UPDATE, emit: 1'b0, cond: COND_ALWAYS,   target: UA_CHECK};
         default:  w = '{op: OP_NONE,   emit: 1'b0, cond: COND_ALWAYS,   target: UA_IDLE};
      endcase
      return w;
   endfunction

endpackage

@@ rtl/lpe_req_if.sv @@
// ----------------------------------------------------------------------------
// Legendre evaluator request channel
// Valid/ready channel carrying the degree and the evaluation point.
// ----------------------------------------------------------------------------
interface lpe_req_if import lpe_pkg::*; ();

   logic                       valid;
   logic                       ready;
   logic [DEGREE_W-1:0]        degree;
   logic signed [VALUE_W-1:0]  x_value;

   modport source (output valid, output degree, output x_value, input ready);
   modport sink   (input valid, input degree, input x_value, output ready);

endinterface

@@ rtl/lpe_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Legendre evaluator response channel
// Valid/ready channel carrying the polynomial value and saturation flag.
// ----------------------------------------------------------------------------
interface lpe_rsp_if import lpe_pkg::*; ();

   logic                       valid;
   logic                       ready;
   logic signed [VALUE_W-1:0]  poly_value;
   logic                       saturated;

   modport source (output valid, output poly_value, output saturated, input ready);
   modport sink   (input valid, input poly_value, input saturated, output ready);

endinterface

@@ rtl/lpe_div_unit.sv @@
// ----------------------------------------------------------------------------
// Legendre evaluator divider
// Unsigned long division of a 64-bit magnitude by a small divisor,
// DIV_BITS quotient bits per cycle while ctl.step is high.
// ----------------------------------------------------------------------------
module lpe_div_unit import lpe_pkg::*; #(
   parameter int DW = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  lpe_div_ctl_type      ctl,
   input  logic [ACC_W-1:0]     dividend,
   input  logic [DW-1:0]        divisor,
   output logic [ACC_W-1:0]     quotient,
   output logic                 last
);

   logic [DW-1:0]        rem_ff, rem_in;
   logic [ACC_W-1:0]     quo_ff, quo_in;
   logic [DW-1:0]        dvsr_ff, dvsr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      logic [DW:0]        trial;
      logic [DW-1:0]      rem_v;
      logic [ACC_W-1:0]   quo_v;
      trial = '0;
      rem_v = rem_ff;
      quo_v = quo_ff;
      for (int k = 0; k < DIV_BITS; k++) begin
         trial = {rem_v, quo_v[ACC_W-1]};
         quo_v = {quo_v[ACC_W-2:0], 1'b0};
         if (trial >= {1'b0, dvsr_ff}) begin
            rem_v    = DW'(trial - {1'b0, dvsr_ff});
            quo_v[0] = 1'b1;
         end else begin
            rem_v = trial[DW-1:0];
         end
      end
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvsr_in = dvsr_ff;
      cnt_in  = cnt_ff;
      if (ctl.load) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvsr_in = divisor;
         cnt_in  = '0;
      end else if (ctl.step) begin
         rem_in = rem_v;
         quo_in = quo_v;
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign quotient = quo_ff;
   assign last     = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      ctl.load |=> (cnt_ff == '0) && (rem_ff == '0))
      else $error("divider not cleared on load");

   a_wrap_after_last: assert property (@(posedge clock) disable iff (reset)
      (ctl.step && !ctl.load && last) |=> (cnt_ff == '0))
      else $error("divider count did not wrap");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != '0) |-> (rem_ff < dvsr_ff))
      else $error("partial remainder not below divisor");

endmodule

@@ rtl/legendre_polynomial_eval_unit.sv @@
// ----------------------------------------------------------------------------
// Legendre polynomial evaluator
// Evaluates P(n) at x by the three-term recurrence in signed fixed point,
// driven by a microcoded sequencer over a shared multiply/divide datapath.
//
//   channel  direction  handshake      payload
//   req      in         valid/ready    degree[4:0], x_value[31:0] signed
//   rsp      out        valid/ready    poly_value[31:0] signed, saturated
//
// Degree 0 or 1 needs no recurrence step; each step at higher degree runs
// the multiply, scale, term, numerator, divide, update and check words,
// and the divider retires 8 quotient bits a cycle in the divide word.
// Synchronous reset returns the sequencer to idle and drops any result.
// A new request is taken while a result waits in the output register;
// the sequencer holds at the output step until that register frees.
// ----------------------------------------------------------------------------
module legendre_polynomial_eval_unit import lpe_pkg::*; #(
   parameter int MAX_DEGREE = 31,
   parameter int FRAC_BITS  = 30
) (
   input  logic       clock,
   input  logic       reset,
   lpe_req_if.sink    req,
   lpe_rsp_if.source  rsp
);

   localparam int DEG_W = $clog2(MAX_DEGREE + 1);
   localparam logic ONE_OVF = (FRAC_BITS >= VALUE_W - 1);
   localparam logic signed [VALUE_W-1:0] ONE_SAT =
      ONE_OVF ? VALUE_MAX : VALUE_W'(64'd1 << FRAC_BITS);

   ucode_word_type             uword;
   logic [UADDR_W-1:0]         upc_ff, upc_in;
   logic signed [VALUE_W-1:0]  x_ff, x_in;
   logic signed [VALUE_W-1:0]  y_ff, y_in;
   logic signed [VALUE_W-1:0]  prev_ff, prev_in;
   logic [DEG_W-1:0]           n_ff, n_in;
   logic [DEG_W-1:0]           i_ff, i_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       neg_ff, neg_in;
   logic                       flag_ff, flag_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                       rsp_sat_ff, rsp_sat_in;

   logic                       accept;
   logic                       out_busy;
   logic                       jump;
   logic [DEG_W-1:0]           n_clamped;
   logic signed [ACC_W-1:0]    prod;
   logic [ACC_W-1:0]           acc_mag;
   logic [ACC_W-1:0]           scaled;
   logic signed [ACC_W-1:0]    term;
   logic signed [ACC_W-1:0]    ip_term;
   logic signed [ACC_W-1:0]    num;
   logic [ACC_W-1:0]           num_mag;
   lpe_div_ctl_type            div_ctl;
   logic [ACC_W-1:0]           quo;
   logic                       div_last;

   assign uword    = ucode_rom(upc_ff);
   assign accept   = (uword.op == OP_LOAD) && req.valid;
   assign out_busy = rsp_valid_ff && !rsp.ready;

   always_comb begin
      if (32'(req.degree) > MAX_DEGREE) begin
         n_clamped = DEG_W'(MAX_DEGREE);
      end else begin
         n_clamped = DEG_W'(req.degree);
      end
   end

   assign prod    = x_ff * y_ff;
   assign acc_mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
   assign scaled  = acc_mag >> FRAC_BITS;
   assign term    = acc_ff * $signed({1'b0, i_ff, 1'b1});
   assign ip_term = prev_ff * $signed({1'b0, i_ff});
   assign num     = acc_ff - ip_term;
   assign num_mag = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);

   assign div_ctl.load = (uword.op == OP_NUM);
   assign div_ctl.step = (uword.op == OP_DIV);

   lpe_div_unit #(
      .DW (DEG_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (num_mag),
      .divisor  (i_ff + 1'b1),
      .quotient (quo),
      .last     (div_last)
   );

   // sequencer
   always_comb begin
      case (uword.cond)
         COND_NEVER:    jump = 1'b0;
         COND_ALWAYS:   jump = 1'b1;
         COND_NO_REQ:   jump = !req.valid;
         COND_DONE:     jump = (i_ff >= n_ff);
         COND_DIV_BUSY: jump = !div_last;
         COND_OUT_BUSY: jump = out_busy;
         default:       jump = 1'b1;
      endcase
      upc_in = jump ? uword.target : upc_ff + 1'b1;
   end

   // datapath
   always_comb begin
      x_in         = x_ff;
      y_in         = y_ff;
      prev_in      = prev_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      flag_in      = flag_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;
      case (uword.op)
         OP_LOAD: begin
            if (accept) begin
               x_in    = req.x_value;
               n_in    = n_clamped;
               i_in    = DEG_W'(1);
               prev_in = ONE_SAT;
               if (n_clamped == '0) begin
                  y_in    = ONE_SAT;
                  flag_in = ONE_OVF;
               end else begin
                  y_in    = req.x_value;
                  flag_in = 1'b0;
               end
            end
         end
         OP_MUL:   acc_in = prod;
         OP_SCALE: acc_in = acc_ff[ACC_W-1] ? -$signed(scaled) : $signed(scaled);
         OP_TERM:  acc_in = term;
         OP_NUM:   neg_in = num[ACC_W-1];
         OP_UPDATE: begin
            prev_in = y_ff;
            i_in    = i_ff + 1'b1;
            if (!neg_ff) begin
               if (quo > ACC_W'(VALUE_MAX)) begin
                  y_in    = VALUE_MAX;
                  flag_in = 1'b1;
               end else begin
                  y_in = $signed(quo[VALUE_W-1:0]);
               end
            end else begin
               if (quo > {{(ACC_W-VALUE_W){1'b0}}, VALUE_MIN}) begin
                  y_in    = VALUE_MIN;
                  flag_in = 1'b1;
               end else begin
                  y_in = $signed(~quo[VALUE_W-1:0] + 1'b1);
               end
            end
         end
         default: begin
         end
      endcase
      if (uword.emit && !out_busy) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = y_ff;
         rsp_sat_in   = flag_ff;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      y_ff         <= y_in;
      prev_ff      <= prev_in;
      n_ff         <= n_in;
      i_ff         <= i_in;
      acc_ff       <= acc_in;
      neg_ff       <= neg_in;
      flag_ff      <= flag_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
      if (reset) begin
         upc_ff       <= UA_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req.ready      = (uword.op == OP_LOAD);
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.poly_value = rsp_value_ff;
   assign rsp.saturated  = rsp_sat_ff;

   a_upc_in_program: assert property (@(posedge clock) disable iff (reset)
      upc_ff <= UA_UPD)
      else $error("microcode address outside program");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == UA_CHECK && n_ff != '0) |-> (i_ff <= n_ff))
      else $error("recurrence index passed degree");

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(upc_ff) == UA_OUT))
      else $error("result raised outside output step");

   a_div_done_before_update: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == UA_UPD) |-> ($past(upc_ff) == UA_DIV) && $past(div_last))
      else $error("update before division finished");

endmodule
